FILE: rtl/mcoc_pkg.sv
// shared types, constants and helpers for the mip chain offset calculator
// no dependencies; used by mcoc_level_unit and mip_chain_offset_calculator_unit in rtl/
package mcoc_pkg;

    // limits of the configuration checks and of the reported offset
    localparam int MAX_DIM_BITS = 14;
    localparam int MAX_IMAGES   = 256;
    localparam int OFFSET_BITS  = 40;

    // field widths
    localparam int DIM_W     = 15;
    localparam int BPU_W     = 5;
    localparam int ALIGN_W   = 9;
    localparam int LVL_W     = 4;
    localparam int IMGC_W    = 9;
    localparam int IMG_W     = 8;
    localparam int PAD_W     = 8;
    localparam int FIELD_W   = 40;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 8;

    // internal datapath widths
    localparam int ROW_W   = 20;                // padded row bytes or block row bytes
    localparam int PROD1_W = ROW_W + DIM_W;     // row bytes times height
    localparam int SIZE_W  = 50;                // one level in bytes
    localparam int SUM_W   = 54;                // a whole chain in bytes
    localparam int LO_W    = SUM_W / 2;         // split of the chain for the image multiply
    localparam int HI_W    = SUM_W - LO_W;
    localparam int PART_W  = HI_W + IMG_W;
    localparam int OFS_W   = 64;

    localparam int LEVEL_COUNT = 16;

    // remainder unit: bits retired per cycle and cycles per row value
    localparam int REM_STEPS  = 4;
    localparam int REM_CYCLES = ROW_W / REM_STEPS;

    localparam logic [DIM_W+1:0]   DIM_LIMIT    = (DIM_W+2)'(1) << MAX_DIM_BITS;
    localparam logic [12:0]        IMAGES_LIMIT = 13'(MAX_IMAGES);
    localparam int                 LIM_BITS     = (OFFSET_BITS < FIELD_W) ? OFFSET_BITS : FIELD_W;
    localparam logic [OFS_W-1:0]   OFS_LIMIT    = (OFS_W'(1) << LIM_BITS) - OFS_W'(1);

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CONFIG   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_WIDTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DEPTH     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_UNIT = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COMPRESSED     = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_ALIGN      = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MIP_LEVELS     = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COUNT    = 8'd7;

    typedef struct packed {
        logic [DIM_W-1:0]   base_width;
        logic [DIM_W-1:0]   base_height;
        logic [DIM_W-1:0]   base_depth;
        logic [BPU_W-1:0]   bytes_per_unit;
        logic               compressed;
        logic [ALIGN_W-1:0] row_align;
        logic [LVL_W-1:0]   mip_levels;
        logic [IMGC_W-1:0]  image_count;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [LVL_W-1:0] lv;
    } lvl_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] size;
        logic [PAD_W-1:0]  pad;
    } lvl_rsp_t;

    // dimension of a level, never below one
    function automatic logic [DIM_W-1:0] halve(input logic [DIM_W-1:0] v,
                                               input logic [LVL_W-1:0] lv);
        logic [DIM_W-1:0] r;
        r = v >> lv;
        return (r == '0) ? DIM_W'(1) : r;
    endfunction

endpackage

FILE: rtl/mcoc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module mcoc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mcoc_level_unit.sv
// byte size and row padding of one mip level, computed over several cycles
// depends on mcoc_pkg
module mcoc_level_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  mcoc_pkg::cfg_t     cfg,
    input  mcoc_pkg::lvl_req_t req,
    output mcoc_pkg::lvl_rsp_t rsp
);

    localparam logic [2:0] LU_IDLE = 3'd0;
    localparam logic [2:0] LU_MUL0 = 3'd1;
    localparam logic [2:0] LU_REM  = 3'd2;
    localparam logic [2:0] LU_PAD  = 3'd3;
    localparam logic [2:0] LU_MUL1 = 3'd4;
    localparam logic [2:0] LU_MUL2 = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       done_reg;

    logic [mcoc_pkg::DIM_W-1:0]   unit_reg;
    logic [mcoc_pkg::DIM_W-1:0]   dim2_reg;
    logic [mcoc_pkg::DIM_W-1:0]   ld_reg;
    logic [mcoc_pkg::ROW_W-1:0]   row_reg;
    logic [mcoc_pkg::ROW_W-1:0]   dvd_reg;
    logic [mcoc_pkg::ALIGN_W-1:0] rem_reg, rem_next;
    logic [2:0]                   cnt_reg;
    logic [mcoc_pkg::PAD_W-1:0]   pad_reg;
    logic [mcoc_pkg::PROD1_W-1:0] m1_reg;
    logic [mcoc_pkg::SIZE_W-1:0]  size_reg;

    logic [mcoc_pkg::DIM_W-1:0] lw, lh, ld;
    logic [mcoc_pkg::DIM_W:0]   bw_sum, bh_sum;
    logic                       needs_pad;
    logic [mcoc_pkg::ALIGN_W-1:0] pad_full;

    always_comb begin
        lw     = mcoc_pkg::halve(cfg.base_width, req.lv);
        lh     = mcoc_pkg::halve(cfg.base_height, req.lv);
        ld     = mcoc_pkg::halve(cfg.base_depth, req.lv);
        // partial 4x4 blocks round up
        bw_sum = ({1'b0, lw} + (mcoc_pkg::DIM_W+1)'(3)) >> 2;
        bh_sum = ({1'b0, lh} + (mcoc_pkg::DIM_W+1)'(3)) >> 2;
    end

    assign needs_pad = !cfg.compressed && (cfg.row_align != '0);

    // restoring remainder, a few bits of the row value per cycle
    always_comb begin
        rem_next = rem_reg;
        for (int i = 0; i < mcoc_pkg::REM_STEPS; i++) begin
            rem_next = {rem_next[mcoc_pkg::ALIGN_W-2:0], dvd_reg[mcoc_pkg::ROW_W-1-i]};
            if (rem_next >= cfg.row_align) begin
                rem_next = rem_next - cfg.row_align;
            end
        end
    end

    assign pad_full = (rem_reg == '0) ? '0 : cfg.row_align - rem_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            LU_IDLE: if (req.start) state_next = LU_MUL0;
            LU_MUL0: state_next = needs_pad ? LU_REM : LU_MUL1;
            LU_REM:  if (cnt_reg == 3'(mcoc_pkg::REM_CYCLES - 1)) state_next = LU_PAD;
            LU_PAD:  state_next = LU_MUL1;
            LU_MUL1: state_next = LU_MUL2;
            LU_MUL2: state_next = LU_IDLE;
            default: state_next = LU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == LU_MUL2);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            LU_IDLE: begin
                if (req.start) begin
                    unit_reg <= cfg.compressed ? bw_sum[mcoc_pkg::DIM_W-1:0] : lw;
                    dim2_reg <= cfg.compressed ? bh_sum[mcoc_pkg::DIM_W-1:0] : lh;
                    ld_reg   <= ld;
                end
            end
            LU_MUL0: begin
                row_reg <= mcoc_pkg::ROW_W'(unit_reg) * mcoc_pkg::ROW_W'(cfg.bytes_per_unit);
                dvd_reg <= mcoc_pkg::ROW_W'(unit_reg) * mcoc_pkg::ROW_W'(cfg.bytes_per_unit);
                rem_reg <= '0;
                cnt_reg <= '0;
                pad_reg <= '0;
            end
            LU_REM: begin
                rem_reg <= rem_next;
                dvd_reg <= dvd_reg << mcoc_pkg::REM_STEPS;
                cnt_reg <= cnt_reg + 3'd1;
            end
            LU_PAD: begin
                pad_reg <= pad_full[mcoc_pkg::PAD_W-1:0];
                row_reg <= row_reg + mcoc_pkg::ROW_W'(pad_full);
            end
            LU_MUL1: begin
                m1_reg <= mcoc_pkg::PROD1_W'(row_reg) * mcoc_pkg::PROD1_W'(dim2_reg);
            end
            LU_MUL2: begin
                size_reg <= mcoc_pkg::SIZE_W'(m1_reg) * mcoc_pkg::SIZE_W'(ld_reg);
            end
            default: ;
        endcase
    end

    assign rsp.done = done_reg;
    assign rsp.size = size_reg;
    assign rsp.pad  = pad_reg;

endmodule

FILE: rtl/mip_chain_offset_calculator_unit.sv
// top level of the mip chain offset calculator: registers, sequencer, level size ram
// depends on mcoc_pkg, mcoc_ram and mcoc_level_unit
//
// For a mip level and an image index the block returns where that level starts
// in storage that holds image_count complete mip chains back to back, together
// with the level's byte size, its width, height and depth, and the padding
// bytes appended to each of its rows. One item is worked on at a time: the
// sequencer walks the levels of one chain through a shared level unit (shift,
// multiply, remainder for the row alignment, two more multiplies), adds each
// level size into the chain total and the bytes in front of the requested
// level, and writes every size into a small level size ram from which the
// requested level's size is read back at the end. An item whose configuration
// passes the checks walks all n+1 levels of the chain, n being the clamped
// level count; with a nonzero row alignment on an uncompressed format each
// level also runs a four bit per cycle remainder loop. A bad configuration or
// an out of range request goes from the check state straight to the done
// state. The next item is taken as soon as the result is in the output
// register. Configuration is to be written by the user through cfg_* only while
// the block is idle; the block does not enforce this and is always ready. Status
// codes: 0 ok, 1 level or image out of range, 2 bad configuration, 3 offset or size saturated.
module mip_chain_offset_calculator_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,   // level[3:0], image_index[11:4], zero
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [135:0]                    m_tdata,   // byte_offset[39:0], level_bytes[79:40],
                                                       // level_width[94:80], level_height[109:95],
                                                       // level_depth[124:110], row_pad[132:125], zero
    output logic [mcoc_pkg::STATUS_W-1:0]   m_tuser,   // status[1:0]
    // configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcoc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcoc_pkg::DIM_W-1:0]      cfg_data
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_LEVEL = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_MULH  = 3'd4;
    localparam logic [2:0] ST_SUM   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    mcoc_pkg::cfg_t cfg_reg;

    logic [2:0] state_reg, state_next;

    // accepted item
    logic [mcoc_pkg::LVL_W-1:0] level_reg;
    logic [mcoc_pkg::IMG_W-1:0] img_reg;

    // chain walk
    logic [mcoc_pkg::LVL_W-1:0]  eff_reg;
    logic [mcoc_pkg::LVL_W-1:0]  lv_reg;
    logic                        start_reg;
    logic [mcoc_pkg::SUM_W-1:0]  chain_reg;
    logic [mcoc_pkg::SUM_W-1:0]  before_reg;
    logic [mcoc_pkg::PAD_W-1:0]  pad_sel_reg;
    logic [mcoc_pkg::PART_W-1:0] lo_reg;
    logic [mcoc_pkg::PART_W-1:0] hi_reg;

    // finished result, waiting for the output register
    logic [mcoc_pkg::STATUS_W-1:0] status_res_reg;
    logic [mcoc_pkg::FIELD_W-1:0]  ofs_res_reg;
    logic [mcoc_pkg::FIELD_W-1:0]  lb_res_reg;
    logic [mcoc_pkg::DIM_W-1:0]    w_res_reg, h_res_reg, d_res_reg;
    logic [mcoc_pkg::PAD_W-1:0]    pad_res_reg;

    // output register
    logic                          m_tvalid_reg;
    logic [mcoc_pkg::STATUS_W-1:0] status_out_reg;
    logic [mcoc_pkg::FIELD_W-1:0]  ofs_out_reg;
    logic [mcoc_pkg::FIELD_W-1:0]  lb_out_reg;
    logic [mcoc_pkg::DIM_W-1:0]    w_out_reg, h_out_reg, d_out_reg;
    logic [mcoc_pkg::PAD_W-1:0]    pad_out_reg;

    mcoc_pkg::lvl_req_t lu_req;
    mcoc_pkg::lvl_rsp_t lu_rsp;

    logic                        ram_we;
    logic                        ram_re;
    logic [mcoc_pkg::SIZE_W-1:0] ram_rdata;

    logic                        s_accept;
    logic                        out_free;
    logic                        last_level;

    // configuration checks and clamped level count
    logic [mcoc_pkg::DIM_W-1:0]  maxd;
    logic [mcoc_pkg::LVL_W-1:0]  maxlev;
    logic [mcoc_pkg::LVL_W-1:0]  eff;
    logic                        bad_cfg;
    logic                        out_of_range;

    // final sum
    logic [mcoc_pkg::OFS_W-1:0]  ofs_sum;
    logic                        ofs_ovf;
    logic                        lb_ovf;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_width     <= mcoc_pkg::DIM_W'(1);
            cfg_reg.base_height    <= mcoc_pkg::DIM_W'(1);
            cfg_reg.base_depth     <= mcoc_pkg::DIM_W'(1);
            cfg_reg.bytes_per_unit <= mcoc_pkg::BPU_W'(4);
            cfg_reg.compressed     <= 1'b0;
            cfg_reg.row_align      <= '0;
            cfg_reg.mip_levels     <= '0;
            cfg_reg.image_count    <= mcoc_pkg::IMGC_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                mcoc_pkg::REG_BASE_WIDTH:     cfg_reg.base_width     <= cfg_data;
                mcoc_pkg::REG_BASE_HEIGHT:    cfg_reg.base_height    <= cfg_data;
                mcoc_pkg::REG_BASE_DEPTH:     cfg_reg.base_depth     <= cfg_data;
                mcoc_pkg::REG_BYTES_PER_UNIT: cfg_reg.bytes_per_unit <= cfg_data[mcoc_pkg::BPU_W-1:0];
                mcoc_pkg::REG_COMPRESSED:     cfg_reg.compressed     <= cfg_data[0];
                mcoc_pkg::REG_ROW_ALIGN:      cfg_reg.row_align      <= cfg_data[mcoc_pkg::ALIGN_W-1:0];
                mcoc_pkg::REG_MIP_LEVELS:     cfg_reg.mip_levels     <= cfg_data[mcoc_pkg::LVL_W-1:0];
                mcoc_pkg::REG_IMAGE_COUNT:    cfg_reg.image_count    <= cfg_data[mcoc_pkg::IMGC_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- checks
    always_comb begin
        maxd = cfg_reg.base_width;
        if (cfg_reg.base_height > maxd) maxd = cfg_reg.base_height;
        if (cfg_reg.base_depth > maxd) maxd = cfg_reg.base_depth;
        // floor(log2) of the largest dimension
        maxlev = '0;
        for (int i = 1; i < mcoc_pkg::DIM_W; i++) begin
            if (maxd[i]) maxlev = mcoc_pkg::LVL_W'(i);
        end
        eff = (cfg_reg.mip_levels < maxlev) ? cfg_reg.mip_levels : maxlev;

        bad_cfg = (cfg_reg.base_width == '0)
               || ({2'b00, cfg_reg.base_width} > mcoc_pkg::DIM_LIMIT)
               || (cfg_reg.base_height == '0)
               || ({2'b00, cfg_reg.base_height} > mcoc_pkg::DIM_LIMIT)
               || (cfg_reg.base_depth == '0)
               || ({2'b00, cfg_reg.base_depth} > mcoc_pkg::DIM_LIMIT)
               || (cfg_reg.bytes_per_unit == '0)
               || (cfg_reg.bytes_per_unit > mcoc_pkg::BPU_W'(16))
               || (cfg_reg.row_align > mcoc_pkg::ALIGN_W'(256))
               || (cfg_reg.image_count == '0)
               || ({4'b0000, cfg_reg.image_count} > mcoc_pkg::IMAGES_LIMIT);

        out_of_range = (level_reg > eff) || ({1'b0, img_reg} >= cfg_reg.image_count);
    end

    // ---------------------------------------------------------------- level unit and ram
    assign lu_req.start = start_reg;
    assign lu_req.lv    = lv_reg;

    mcoc_level_unit u_level (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .req     (lu_req),
        .rsp     (lu_rsp)
    );

    assign last_level = (lv_reg == eff_reg);
    assign ram_we     = (state_reg == ST_LEVEL) && lu_rsp.done;
    assign ram_re     = (state_reg == ST_READ);

    // the read of the requested level is issued only after the last write of
    // the chain walk, so write and read never meet on one entry in one cycle
    mcoc_ram #(
        .WIDTH (mcoc_pkg::SIZE_W),
        .DEPTH (mcoc_pkg::LEVEL_COUNT)
    ) u_size_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (lv_reg),
        .wdata (lu_rsp.size),
        .re    (ram_re),
        .raddr (level_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- final sum
    always_comb begin
        ofs_sum = mcoc_pkg::OFS_W'({hi_reg, {mcoc_pkg::LO_W{1'b0}}})
                + mcoc_pkg::OFS_W'(lo_reg)
                + mcoc_pkg::OFS_W'(before_reg);
        ofs_ovf = ofs_sum > mcoc_pkg::OFS_LIMIT;
        lb_ovf  = mcoc_pkg::OFS_W'(ram_rdata) > mcoc_pkg::OFS_LIMIT;
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_accept) state_next = ST_CHECK;
            ST_CHECK: state_next = (bad_cfg || out_of_range) ? ST_DONE : ST_LEVEL;
            ST_LEVEL: if (lu_rsp.done && last_level) state_next = ST_READ;
            ST_READ:  state_next = ST_MULH;
            ST_MULH:  state_next = ST_SUM;
            ST_SUM:   state_next = ST_DONE;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            start_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= ((state_reg == ST_CHECK) && !bad_cfg && !out_of_range)
                      || ((state_reg == ST_LEVEL) && lu_rsp.done && !last_level);
            if ((state_reg == ST_DONE) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath of the walk
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    level_reg <= s_tdata[3:0];
                    img_reg   <= s_tdata[11:4];
                end
            end
            ST_CHECK: begin
                eff_reg     <= eff;
                lv_reg      <= '0;
                chain_reg   <= '0;
                before_reg  <= '0;
                pad_sel_reg <= '0;
                // rejected items carry fixed fields
                status_res_reg <= bad_cfg ? mcoc_pkg::STATUS_CONFIG : mcoc_pkg::STATUS_RANGE;
                ofs_res_reg    <= '0;
                lb_res_reg     <= '0;
                w_res_reg      <= mcoc_pkg::DIM_W'(1);
                h_res_reg      <= mcoc_pkg::DIM_W'(1);
                d_res_reg      <= mcoc_pkg::DIM_W'(1);
                pad_res_reg    <= '0;
            end
            ST_LEVEL: begin
                if (lu_rsp.done) begin
                    chain_reg <= chain_reg + mcoc_pkg::SUM_W'(lu_rsp.size);
                    if (lv_reg < level_reg) begin
                        before_reg <= before_reg + mcoc_pkg::SUM_W'(lu_rsp.size);
                    end
                    if (lv_reg == level_reg) begin
                        pad_sel_reg <= lu_rsp.pad;
                    end
                    if (!last_level) begin
                        lv_reg <= lv_reg + mcoc_pkg::LVL_W'(1);
                    end
                end
            end
            ST_READ: begin
                // low half of image_index * chain
                lo_reg <= mcoc_pkg::PART_W'(chain_reg[mcoc_pkg::LO_W-1:0])
                        * mcoc_pkg::PART_W'(img_reg);
            end
            ST_MULH: begin
                hi_reg <= mcoc_pkg::PART_W'(chain_reg[mcoc_pkg::SUM_W-1:mcoc_pkg::LO_W])
                        * mcoc_pkg::PART_W'(img_reg);
            end
            ST_SUM: begin
                status_res_reg <= (ofs_ovf || lb_ovf) ? mcoc_pkg::STATUS_OVERFLOW
                                                      : mcoc_pkg::STATUS_OK;
                ofs_res_reg <= ofs_ovf ? mcoc_pkg::OFS_LIMIT[mcoc_pkg::FIELD_W-1:0]
                                       : ofs_sum[mcoc_pkg::FIELD_W-1:0];
                lb_res_reg  <= lb_ovf ? mcoc_pkg::OFS_LIMIT[mcoc_pkg::FIELD_W-1:0]
                                      : ram_rdata[mcoc_pkg::FIELD_W-1:0];
                w_res_reg   <= mcoc_pkg::halve(cfg_reg.base_width, level_reg);
                h_res_reg   <= mcoc_pkg::halve(cfg_reg.base_height, level_reg);
                d_res_reg   <= mcoc_pkg::halve(cfg_reg.base_depth, level_reg);
                pad_res_reg <= pad_sel_reg;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DONE) && out_free) begin
            status_out_reg <= status_res_reg;
            ofs_out_reg    <= ofs_res_reg;
            lb_out_reg     <= lb_res_reg;
            w_out_reg      <= w_res_reg;
            h_out_reg      <= h_res_reg;
            d_out_reg      <= d_res_reg;
            pad_out_reg    <= pad_res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_out_reg;
    assign m_tdata  = {3'b000, pad_out_reg, d_out_reg, h_out_reg, w_out_reg,
                       lb_out_reg, ofs_out_reg};

`ifndef SYNTHESIS
    // the level unit only finishes while the walk waits for it
    a_done_in_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        lu_rsp.done |-> (state_reg == ST_LEVEL))
        else $error("level unit finished outside the chain walk");

    // sizes are written only for levels inside the clamped chain
    a_write_in_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (lv_reg <= eff_reg))
        else $error("level size written beyond the clamped level count");

    // bytes in front of the level are a part of the chain total
    a_before_in_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LEVEL) |-> (before_reg <= chain_reg))
        else $error("bytes before the level exceed the chain total");

    // rejected items carry the fixed fields
    a_reject_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && ((status_out_reg == mcoc_pkg::STATUS_RANGE)
                       || (status_out_reg == mcoc_pkg::STATUS_CONFIG)))
        |-> (ofs_out_reg == '0 && lb_out_reg == '0 && pad_out_reg == '0
             && w_out_reg == mcoc_pkg::DIM_W'(1)))
        else $error("rejected item with nonzero result fields");
`endif

endmodule

FILE: test/mcoc_checker.sv
// result checker for the mip chain offset calculator: tracks register writes,
// predicts one placement per accepted lookup and compares every returned item
// depends on mcoc_pkg
`timescale 1ns / 100ps

module mcoc_checker
    import mcoc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [15:0]            s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [135:0]           m_tdata,
    input  logic [STATUS_W-1:0]    m_tuser,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    output int                     pending_count,
    output int                     checked_count,
    output int                     failures
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FIELD_W-1:0]  byte_offset;
        logic [FIELD_W-1:0]  level_bytes;
        logic [DIM_W-1:0]    level_width;
        logic [DIM_W-1:0]    level_height;
        logic [DIM_W-1:0]    level_depth;
        logic [PAD_W-1:0]    row_pad;
    } placement_t;

    typedef struct packed {
        logic [63:0] bytes;
        logic [31:0] w;
        logic [31:0] h;
        logic [31:0] d;
        logic [31:0] pad;
    } level_geom_t;

    cfg_t       regs;
    placement_t expected_placements[$];

    initial begin
        pending_count = 0;
        checked_count = 0;
        failures      = 0;
    end

    function automatic logic [31:0] shrink(input logic [DIM_W-1:0] v, input int unsigned lv);
        logic [31:0] r;
        r = 32'(v) >> lv;
        return (r == 0) ? 32'd1 : r;
    endfunction

    // byte size and shape of one level under the given registers
    function automatic level_geom_t size_level(input cfg_t c, input int unsigned lv);
        level_geom_t g;
        logic [31:0] rb;
        g.w   = shrink(c.base_width, lv);
        g.h   = shrink(c.base_height, lv);
        g.d   = shrink(c.base_depth, lv);
        g.pad = 0;
        if (c.compressed) begin
            g.bytes = 64'((g.w + 3) >> 2) * 64'((g.h + 3) >> 2) * 64'(g.d)
                      * 64'(c.bytes_per_unit);
        end else begin
            rb = g.w * 32'(c.bytes_per_unit);
            if (c.row_align != 0 && (rb % 32'(c.row_align)) != 0)
                g.pad = 32'(c.row_align) - rb % 32'(c.row_align);
            g.bytes = 64'(rb + g.pad) * 64'(g.h) * 64'(g.d);
        end
        return g;
    endfunction

    function automatic placement_t locate_level(input cfg_t c, input logic [LVL_W-1:0] lvl,
                                                input logic [IMG_W-1:0] img);
        placement_t  p;
        level_geom_t g;
        logic [63:0] chain, ahead, ofs, span;
        int unsigned big, ceiling, eff;
        p.status       = STATUS_OK;
        p.byte_offset  = '0;
        p.level_bytes  = '0;
        p.level_width  = DIM_W'(1);
        p.level_height = DIM_W'(1);
        p.level_depth  = DIM_W'(1);
        p.row_pad      = '0;
        if (c.base_width == 0 || c.base_width > (1 << MAX_DIM_BITS) ||
            c.base_height == 0 || c.base_height > (1 << MAX_DIM_BITS) ||
            c.base_depth == 0 || c.base_depth > (1 << MAX_DIM_BITS) ||
            c.bytes_per_unit == 0 || c.bytes_per_unit > 16 ||
            c.row_align > 256 || c.image_count == 0 || c.image_count > MAX_IMAGES) begin
            p.status = STATUS_CONFIG;
            return p;
        end
        // level count is clamped by the largest base dimension
        big = c.base_width;
        if (c.base_height > big) big = c.base_height;
        if (c.base_depth > big) big = c.base_depth;
        ceiling = 0;
        while ((big >> 1) != 0) begin
            big = big >> 1;
            ceiling++;
        end
        eff = (c.mip_levels < ceiling) ? c.mip_levels : ceiling;
        if (lvl > eff || img >= c.image_count) begin
            p.status = STATUS_RANGE;
            return p;
        end
        chain = 0;
        ahead = 0;
        for (int unsigned lv = 0; lv <= eff; lv++) begin
            g = size_level(c, lv);
            chain += g.bytes;
            if (lv < lvl) ahead += g.bytes;
        end
        g    = size_level(c, lvl);
        ofs  = 64'(img) * chain + ahead;
        span = g.bytes;
        if (ofs > OFS_LIMIT) begin
            ofs      = OFS_LIMIT;
            p.status = STATUS_OVERFLOW;
        end
        if (span > OFS_LIMIT) begin
            span     = OFS_LIMIT;
            p.status = STATUS_OVERFLOW;
        end
        p.byte_offset  = ofs[FIELD_W-1:0];
        p.level_bytes  = span[FIELD_W-1:0];
        p.level_width  = g.w[DIM_W-1:0];
        p.level_height = g.h[DIM_W-1:0];
        p.level_depth  = g.d[DIM_W-1:0];
        p.row_pad      = g.pad[PAD_W-1:0];
        return p;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        placement_t want;
        if (!aresetn) begin
            regs.base_width     = DIM_W'(1);
            regs.base_height    = DIM_W'(1);
            regs.base_depth     = DIM_W'(1);
            regs.bytes_per_unit = BPU_W'(4);
            regs.compressed     = 1'b0;
            regs.row_align      = '0;
            regs.mip_levels     = '0;
            regs.image_count    = IMGC_W'(1);
            expected_placements.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BASE_WIDTH:     regs.base_width     = cfg_data;
                    REG_BASE_HEIGHT:    regs.base_height    = cfg_data;
                    REG_BASE_DEPTH:     regs.base_depth     = cfg_data;
                    REG_BYTES_PER_UNIT: regs.bytes_per_unit = cfg_data[BPU_W-1:0];
                    REG_COMPRESSED:     regs.compressed     = cfg_data[0];
                    REG_ROW_ALIGN:      regs.row_align      = cfg_data[ALIGN_W-1:0];
                    REG_MIP_LEVELS:     regs.mip_levels     = cfg_data[LVL_W-1:0];
                    REG_IMAGE_COUNT:    regs.image_count    = cfg_data[IMGC_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_placements.push_back(locate_level(regs, s_tdata[3:0], s_tdata[11:4]));
            if (m_tvalid && m_tready) begin
                if (expected_placements.size() == 0) begin
                    $error("result item with no lookup outstanding");
                    failures++;
                end else begin
                    want = expected_placements.pop_front();
                    check_field("status", want.status, m_tuser);
                    check_field("byte_offset", want.byte_offset, m_tdata[39:0]);
                    check_field("level_bytes", want.level_bytes, m_tdata[79:40]);
                    check_field("level_width", want.level_width, m_tdata[94:80]);
                    check_field("level_height", want.level_height, m_tdata[109:95]);
                    check_field("level_depth", want.level_depth, m_tdata[124:110]);
                    check_field("row_pad", want.row_pad, m_tdata[132:125]);
                    checked_count++;
                end
            end
        end
        pending_count = expected_placements.size();
    end

endmodule

FILE: test/tb.sv
// top of the mip chain offset calculator testbench: clock, reset, register
// programming, lookup stimulus and verdict; depends on mcoc_pkg, mcoc_checker
// and the rtl top mip_chain_offset_calculator_unit
`timescale 1ns / 100ps

module tb;
    import mcoc_pkg::*;

    // unused register index, writes there must leave every register alone
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 8'd8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;   // level[3:0], image_index[11:4], zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [135:0]          m_tdata;          // byte_offset, level_bytes, width, height,
                                             // depth, row_pad from bit 0 up
    logic [STATUS_W-1:0]   m_tuser;          // status
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [DIM_W-1:0]      cfg_data  = '0;

    int   pending_count, checked_count, failures;
    int   lookups_sent = 0;
    int   settings_loaded = 0;
    bit   quiet = 1'b0;       // no idling on either side while set
    cfg_t cur_cfg;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    mip_chain_offset_calculator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mcoc_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending_count (pending_count),
        .checked_count (checked_count),
        .failures      (failures)
    );

    // result backpressure: m_tready drops roughly 6 times in a hundred
    always @(negedge aclk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 6);
    end

    // generous ceiling on run time, the slowest lookups included, under a thousand lookups
    initial begin
        #4000000;
        $display("FAIL mip_chain_offset_calculator_unit");
        $finish;
    end

    function automatic cfg_t make_cfg(input int w, input int h, input int d, input int bpu,
                                      input int comp, input int align, input int mips,
                                      input int imgs);
        cfg_t c;
        c.base_width     = DIM_W'(w);
        c.base_height    = DIM_W'(h);
        c.base_depth     = DIM_W'(d);
        c.bytes_per_unit = BPU_W'(bpu);
        c.compressed     = comp[0];
        c.row_align      = ALIGN_W'(align);
        c.mip_levels     = LVL_W'(mips);
        c.image_count    = IMGC_W'(imgs);
        return c;
    endfunction

    function automatic int reg_bits(input logic [CFG_IDX_W-1:0] idx);
        case (idx)
            REG_BYTES_PER_UNIT: return BPU_W;
            REG_COMPRESSED:     return 1;
            REG_ROW_ALIGN:      return ALIGN_W;
            REG_MIP_LEVELS:     return LVL_W;
            REG_IMAGE_COUNT:    return IMGC_W;
            default:            return DIM_W;
        endcase
    endfunction

    // deepest level reachable under a setting, used only to aim the stimulus
    function automatic int level_ceiling(input cfg_t c);
        int big, n;
        big = c.base_width;
        if (c.base_height > big) big = c.base_height;
        if (c.base_depth > big) big = c.base_depth;
        n = 0;
        while (big > 1) begin
            big = big >> 1;
            n++;
        end
        return (c.mip_levels < n) ? c.mip_levels : n;
    endfunction

    // random setting: mostly legal, small depths, sometimes one field made illegal
    function automatic cfg_t rand_config();
        cfg_t c;
        c = make_cfg($urandom_range(1, 1 << $urandom_range(0, 14)),
                     $urandom_range(1, 1 << $urandom_range(0, 14)),
                     ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(1, 1 << $urandom_range(0, 8)),
                     $urandom_range(1, 16), $urandom_range(0, 1), 0,
                     $urandom_range(0, 15), $urandom_range(1, 256));
        case ($urandom_range(0, 3))
            0:       c.row_align = '0;
            1:       c.row_align = ALIGN_W'(1 << $urandom_range(0, 8));
            default: c.row_align = ALIGN_W'($urandom_range(1, 256));
        endcase
        if (c.image_count > 16 && $urandom_range(0, 1)) c.image_count = IMGC_W'($urandom_range(1, 16));
        if ($urandom_range(0, 99) < 8) begin
            case ($urandom_range(0, 5))
                0: c.base_width     = $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(16385, 32767));
                1: c.base_height    = $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(16385, 32767));
                2: c.base_depth     = $urandom_range(0, 1) ? '0 : DIM_W'($urandom_range(16385, 32767));
                3: c.bytes_per_unit = $urandom_range(0, 1) ? '0 : BPU_W'($urandom_range(17, 31));
                4: c.row_align      = ALIGN_W'($urandom_range(257, 511));
                default: c.image_count = $urandom_range(0, 1) ? '0 : IMGC_W'($urandom_range(257, 511));
            endcase
        end
        return c;
    endfunction

    // one register write; bits above the register's width carry junk the block must drop
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        logic [31:0] junk;
        junk      = $urandom;
        junk      = (junk >> reg_bits(idx)) << reg_bits(idx);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= DIM_W'(junk) | value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // drain outstanding lookups, then program a whole setting while the block is idle
    task automatic settle_and_load(input cfg_t c);
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        write_reg(REG_BASE_WIDTH, c.base_width);
        write_reg(REG_BASE_HEIGHT, c.base_height);
        write_reg(REG_BASE_DEPTH, c.base_depth);
        write_reg(REG_BYTES_PER_UNIT, DIM_W'(c.bytes_per_unit));
        write_reg(REG_COMPRESSED, DIM_W'(c.compressed));
        write_reg(REG_ROW_ALIGN, DIM_W'(c.row_align));
        write_reg(REG_MIP_LEVELS, DIM_W'(c.mip_levels));
        write_reg(REG_IMAGE_COUNT, DIM_W'(c.image_count));
        // a write to an unused index goes last so any aliasing shows up
        if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, DIM_W'($urandom));
        cfg_valid <= 1'b0;
        cur_cfg = c;
        settings_loaded++;
    endtask

    // one lookup item, with an occasional gap in front of it; called at a falling edge
    task automatic send_lookup(input int lvl, input int img);
        while (!quiet && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 16'($urandom);
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, 8'(img), 4'(lvl)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        lookups_sent++;
        @(negedge aclk);
    endtask

    initial begin
        int ceil_lvl;
        cur_cfg = make_cfg(1, 1, 1, 4, 0, 0, 0, 1);
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset setting: a single 1x1x1 level in one chain
        send_lookup(0, 0);
        send_lookup(1, 0);
        send_lookup(0, 1);
        send_lookup(15, 255);

        // odd sizes, byte padded rows, mip count above what the dimensions allow
        settle_and_load(make_cfg(37, 20, 3, 3, 0, 8, 15, 4));
        send_lookup(0, 0);
        send_lookup(3, 1);
        send_lookup(5, 3);
        send_lookup(6, 0);
        send_lookup(0, 4);

        // every register but the mip count at its legal maximum, compressed: the size itself saturates
        settle_and_load(make_cfg(16384, 16384, 16384, 16, 1, 256, 14, 256));
        send_lookup(0, 0);
        send_lookup(14, 255);
        send_lookup(0, 255);

        // level sizes fit but the offset of the last chain passes the 40 bit limit
        settle_and_load(make_cfg(4096, 4096, 64, 4, 0, 256, 12, 256));
        send_lookup(0, 255);
        send_lookup(12, 255);

        // alignment that is not a power of two
        settle_and_load(make_cfg(13, 7, 1, 3, 0, 7, 3, 2));
        send_lookup(0, 0);
        send_lookup(1, 1);
        send_lookup(2, 0);
        send_lookup(3, 1);

        // illegal settings, one field each, all bits of the wider fields set somewhere
        settle_and_load(make_cfg(0, 8, 8, 4, 0, 0, 2, 1));
        send_lookup(0, 0);
        settle_and_load(make_cfg(8, 16385, 8, 4, 0, 0, 2, 1));
        send_lookup(0, 0);
        settle_and_load(make_cfg(8, 8, 32767, 4, 0, 0, 2, 1));
        send_lookup(1, 0);
        settle_and_load(make_cfg(8, 8, 8, 31, 1, 0, 2, 1));
        send_lookup(0, 0);
        settle_and_load(make_cfg(8, 8, 8, 4, 0, 511, 2, 1));
        send_lookup(0, 0);
        settle_and_load(make_cfg(8, 8, 8, 4, 0, 0, 2, 0));
        send_lookup(0, 0);
        settle_and_load(make_cfg(8, 8, 8, 4, 0, 0, 2, 511));
        send_lookup(0, 0);

        // random settings, mostly lookups that land inside the chain array;
        // a few settings in the middle run with no idling on either side
        for (int ph = 0; ph < 15; ph++) begin
            quiet = (ph >= 6 && ph < 9);
            settle_and_load(rand_config());
            ceil_lvl = level_ceiling(cur_cfg);
            repeat (50) begin
                if ($urandom_range(0, 99) < 15 || cur_cfg.image_count == 0 ||
                    cur_cfg.image_count > 256)
                    send_lookup($urandom_range(0, 15), $urandom_range(0, 255));
                else
                    send_lookup($urandom_range(0, ceil_lvl),
                                $urandom_range(0, cur_cfg.image_count - 1));
            end
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        // room for a stray result after the last one, longer than the slowest lookup
        repeat (200) @(negedge aclk);

        $display("covered %0d lookups under %0d register settings, %0d results compared",
                 lookups_sent, settings_loaded, checked_count);
        if (failures == 0) begin
            $display("PASS mip_chain_offset_calculator_unit");
        end else begin
            $display("FAIL mip_chain_offset_calculator_unit");
        end
        $finish;
    end

endmodule
